// ===== src/aedm_pkg.sv =====
// Shared constants and types of the audio echo delay mixer.
package aedm_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DELAY_W       = 14;
    localparam int VOL_W         = 15;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 15;
    localparam int DIV_CNT_W     = 4;
    localparam int DEPTH_DEFAULT = 8192;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 14'd8000;
    localparam logic [VOL_W-1:0]   VOL_RESET   = 15'd4;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DIVISOR = 1'b1;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quot;
    } aedm_div_out_t;

endpackage

// ===== src/aedm_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module aedm_div
    import aedm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] dividend,
    input  logic [VOL_W-1:0]           divisor,
    output aedm_div_out_t              res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0]  mag_reg, mag_next;
    logic [VOL_W-1:0]     rem_reg, rem_next;
    logic [VOL_W-1:0]     div_reg;
    logic                 neg_reg;
    logic [SAMPLE_W-1:0]  trial;
    logic [SAMPLE_W-1:0]  diff;
    logic                 ge;

    assign trial = {rem_reg, mag_reg[SAMPLE_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            mag_next  = dividend[SAMPLE_W-1] ? SAMPLE_W'(-dividend) : SAMPLE_W'(dividend);
        end else if (busy_reg) begin
            rem_next = ge ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
            mag_next = {mag_reg[SAMPLE_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        if (start) begin
            neg_reg <= dividend[SAMPLE_W-1];
            div_reg <= divisor;
        end
    end

    assign res.done = done_reg;
    assign res.quot = neg_reg ? SAMPLE_W'(-mag_reg) : mag_reg;

endmodule

// ===== src/audio_echo_delay_mixer.sv =====
// Feed-forward echo on a signed 16-bit mono stream: y = x + x[t-delay] / volume, wrapped.
// A sample transaction reads the history memory when it is accepted, then writes the new sample
// back and starts the divider, waits out the divider's bit-serial steps, forms the sum, and then
// loads the output register once it is free. A drain transaction past the end of the tail skips
// the history write and the divider. The output register lets a new transaction be accepted while
// the previous result still waits. The history memory needs no clearing pass after reset, as a
// fill count stands in for its reset contents.
module audio_echo_delay_mixer
    import aedm_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,    // sample_in
    input  logic                  s_tuser,    // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // sample_out
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int EW_RAW = $clog2(RING_DEPTH + 1);
    localparam int EW    = (EW_RAW > DELAY_W) ? EW_RAW : DELAY_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [EW-1:0]       filled_reg, filled_next;
    logic [EW-1:0]       drain_cnt_reg, drain_cnt_next;
    logic [DELAY_W-1:0]  delay_reg;
    logic [VOL_W-1:0]    vol_reg;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic                m_last_reg;

    logic                cmd_reg;
    logic [SAMPLE_W-1:0] x_reg;
    logic                echo_en_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] res_reg;
    logic                last_reg;

    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    logic [EW-1:0]       dly_ext;
    logic [EW-1:0]       d_eff;
    logic [EW:0]         back;
    logic [EW:0]         back_wrap;
    logic [AW-1:0]       rd_addr;
    logic                s_acc;
    logic                drain_in;
    logic                tail_done;
    logic                wr_en;
    logic                out_load;
    logic [EW-1:0]       drain_inc;
    logic [VOL_W-1:0]    vol_eff;
    logic [SAMPLE_W-1:0] div_dividend;
    aedm_div_out_t       div_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign drain_in  = (s_tuser == CMD_DRAIN);

    assign dly_ext = EW'(delay_reg);
    assign d_eff   = (dly_ext == '0) ? EW'(1) :
                     (dly_ext > EW'(RING_DEPTH)) ? EW'(RING_DEPTH) : dly_ext;

    assign back      = {1'b0, EW'(ptr_reg)} - {1'b0, d_eff};
    assign back_wrap = back + (EW + 1)'(RING_DEPTH);
    assign rd_addr   = back[EW] ? back_wrap[AW-1:0] : back[AW-1:0];

    assign tail_done    = drain_in && (drain_cnt_reg >= d_eff);
    assign wr_en        = (state_reg == ST_LOAD);
    assign out_load     = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);
    assign drain_inc    = drain_cnt_reg + 1'b1;
    assign vol_eff      = (vol_reg == '0) ? VOL_W'(1) : vol_reg;
    assign div_dividend = echo_en_reg ? rd_data_reg : '0;

    aedm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (wr_en),
        .dividend (div_dividend),
        .divisor  (vol_eff),
        .res      (div_out)
    );

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        filled_next    = filled_reg;
        drain_cnt_next = drain_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = tail_done ? ST_FIN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                ptr_next = (ptr_reg == AW'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                if (filled_reg < EW'(RING_DEPTH)) begin
                    filled_next = filled_reg + 1'b1;
                end
                drain_cnt_next = (cmd_reg == CMD_DRAIN) ? drain_inc : '0;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_out.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            filled_reg    <= '0;
            drain_cnt_reg <= '0;
            delay_reg     <= DELAY_RESET;
            vol_reg       <= VOL_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            filled_reg    <= filled_next;
            drain_cnt_reg <= drain_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ECHO_DELAY:     delay_reg <= cfg_data[DELAY_W-1:0];
                    CFG_VOLUME_DIVISOR: vol_reg   <= cfg_data[VOL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (wr_en) begin
            ring_mem[ptr_reg] <= x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg     <= s_tuser;
            x_reg       <= drain_in ? '0 : s_tdata;
            echo_en_reg <= (filled_reg >= d_eff);
            if (tail_done) begin
                res_reg  <= '0;
                last_reg <= 1'b1;
            end
        end
        if (wr_en) begin
            last_reg <= (cmd_reg == CMD_DRAIN) && (drain_inc >= d_eff);
        end
        if ((state_reg == ST_DIV) && div_out.done) begin
            res_reg <= x_reg + div_out.quot;
        end
        if (out_load) begin
            m_data_reg <= res_reg;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= EW'(RING_DEPTH))
        else $error("fill count exceeds the history depth");

    a_load_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> $past(s_tvalid && s_tready))
        else $error("history write without an accepted transaction");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule

// ===== sim/aedm_echo_checker.sv =====
`timescale 1ns / 100ps
// Checker for the audio echo delay mixer: predicts every result and compares it field by field.
module aedm_echo_checker
    import aedm_pkg::*;
#(
    parameter int RING_DEPTH = DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [SAMPLE_W-1:0]   m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    outstanding,
    output int                    tail_marks
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                last;
    } mix_result_t;

    logic [SAMPLE_W-1:0] history [RING_DEPTH];
    int                  write_slot;
    int                  fill_level;
    int                  drain_run;
    logic [DELAY_W-1:0]  delay_reg;
    logic [VOL_W-1:0]    divisor_reg;
    mix_result_t         expected_mix_q[$];
    int                  errors = 0;
    int                  tails  = 0;

    function automatic mix_result_t mix_echo(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        int          span;
        int          divisor;
        int          dry;
        int          echo;
        int          slot;
        mix_result_t res;
        span    = (delay_reg == '0) ? 1 :
                  ((int'(delay_reg) > RING_DEPTH) ? RING_DEPTH : int'(delay_reg));
        divisor = (divisor_reg == '0) ? 1 : int'(divisor_reg);
        res.last = 1'b0;
        if (cmd == CMD_DRAIN && drain_run >= span) begin
            res.sample_out = '0;
            res.last       = 1'b1;
            return res;
        end
        dry  = (cmd == CMD_DRAIN) ? 0 : int'($signed(smp));
        echo = 0;
        if (fill_level >= span) begin
            slot = (write_slot + RING_DEPTH - span) % RING_DEPTH;
            echo = int'($signed(history[slot])) / divisor;
        end
        res.sample_out      = SAMPLE_W'(dry + echo);
        history[write_slot] = SAMPLE_W'(dry);
        write_slot          = (write_slot + 1) % RING_DEPTH;
        if (fill_level < RING_DEPTH) fill_level++;
        if (cmd == CMD_DRAIN) begin
            drain_run++;
            res.last = (drain_run >= span);
        end else begin
            drain_run = 0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        mix_result_t want;
        if (!aresetn) begin
            foreach (history[i]) history[i] = '0;
            write_slot  = 0;
            fill_level  = 0;
            drain_run   = 0;
            delay_reg   = DELAY_RESET;
            divisor_reg = VOL_RESET;
            expected_mix_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ECHO_DELAY) begin
                    delay_reg = cfg_data[DELAY_W-1:0];
                end else if (cfg_index == CFG_VOLUME_DIVISOR) begin
                    divisor_reg = cfg_data[VOL_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_mix_q.size() == 0) begin
                    $error("Result transaction with nothing expected: sample_out %0d, last %0b",
                           $signed(m_tdata), m_tlast);
                    errors++;
                end else begin
                    want = expected_mix_q.pop_front();
                    if (m_tdata !== want.sample_out) begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.sample_out), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        errors++;
                    end
                    if (want.last) tails++;
                end
            end
            if (s_tvalid && s_tready) expected_mix_q.push_back(mix_echo(s_tuser, s_tdata));
        end
        mismatch_count <= errors;
        outstanding    <= expected_mix_q.size();
        tail_marks     <= tails;
    end

endmodule

// ===== sim/tb_audio_echo_delay_mixer.sv =====
`timescale 1ns / 100ps
// Testbench top for the audio echo delay mixer: drives stimulus and reports the verdict.
module tb_audio_echo_delay_mixer
    import aedm_pkg::*;
;

    localparam int DEPTH = DEPTH_DEFAULT;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = CMD_PUSH;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ECHO_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   mismatch_count;
    int   outstanding;
    int   tail_marks;
    int   n_push    = 0;
    int   n_drain   = 0;
    int   n_cfg     = 0;
    int   cur_delay = 8000;
    logic no_idle   = 1'b0;

    audio_echo_delay_mixer #(.RING_DEPTH(DEPTH)) dut (.*);

    aedm_echo_checker #(.RING_DEPTH(DEPTH)) u_checker (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
    end

    function automatic int eff_delay(input logic [CFG_DATA_W-1:0] val);
        int d;
        d = int'(val[DELAY_W-1:0]);
        if (d == 0) d = 1;
        if (d > DEPTH) d = DEPTH;
        return d;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return SAMPLE_W'($urandom_range(0, 3));
            3: return 16'hFFFF - SAMPLE_W'($urandom_range(0, 3));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        if (!no_idle && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_DRAIN) n_drain++;
        else n_push++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
        if (idx == CFG_ECHO_DELAY) cur_delay = eff_delay(val);
        @(posedge aclk);
    endtask

    // Holds the input back until every outstanding result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int                    start;
        int                    tail;
        bit                    noisy;
        bit                    first_seg;
        logic [CFG_DATA_W-1:0] delay_val;
        logic [CFG_DATA_W-1:0] vol_val;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings after reset, extreme samples and a drain well short of the tail.
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h0000);
        send_item(CMD_PUSH, 16'hFFFF);
        send_item(CMD_DRAIN, 16'h1234);

        // A zero delay and a zero divisor both act as one; the sums wrap.
        wait_drained();
        write_reg(CFG_ECHO_DELAY, '0);
        write_reg(CFG_VOLUME_DIVISOR, '0);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_DRAIN, 16'hA5A5);
        send_item(CMD_DRAIN, 16'h5A5A);
        send_item(CMD_PUSH, 16'h0005);

        // Largest divisor, truncation toward zero, a full tail and a drain past it.
        wait_drained();
        write_reg(CFG_ECHO_DELAY, CFG_DATA_W'(3));
        write_reg(CFG_VOLUME_DIVISOR, 15'h7FFF);
        send_item(CMD_PUSH, 16'h8000);
        send_item(CMD_PUSH, 16'h7FFF);
        send_item(CMD_PUSH, 16'h0001);
        send_item(CMD_PUSH, 16'h0064);
        repeat (4) send_item(CMD_DRAIN, SAMPLE_W'($urandom));

        // The delay changes in the middle of a stream.
        wait_drained();
        write_reg(CFG_ECHO_DELAY, CFG_DATA_W'(2));
        send_item(CMD_PUSH, 16'h8001);
        send_item(CMD_PUSH, 16'h0007);

        start     = n_push + n_drain;
        first_seg = 1'b1;
        while (n_push + n_drain - start < 960) begin
            if (first_seg || $urandom_range(0, 3) == 0) begin
                first_seg = 1'b0;
                wait_drained();
                case ($urandom_range(0, 9))
                    0: delay_val = '0;
                    1: delay_val = CFG_DATA_W'($urandom_range(DEPTH + 1, 2**CFG_DATA_W - 1));
                    2: delay_val = CFG_DATA_W'($urandom_range(40, DEPTH));
                    default: delay_val = CFG_DATA_W'($urandom_range(1, 24));
                endcase
                case ($urandom_range(0, 9))
                    0: vol_val = '0;
                    1: vol_val = CFG_DATA_W'(1);
                    2: vol_val = 15'h7FFF;
                    3: vol_val = CFG_DATA_W'($urandom);
                    default: vol_val = CFG_DATA_W'($urandom_range(2, 9));
                endcase
                write_reg(CFG_VOLUME_DIVISOR, vol_val);
                write_reg(CFG_ECHO_DELAY, delay_val);
            end
            noisy = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 40)) begin
                send_item((noisy && $urandom_range(0, 3) == 0) ? CMD_DRAIN : CMD_PUSH,
                          pick_sample());
            end
            if (cur_delay > 64 || $urandom_range(0, 4) == 0) begin
                tail = $urandom_range(0, 8);
            end else begin
                tail = cur_delay + $urandom_range(0, 3);
            end
            repeat (tail) send_item(CMD_DRAIN, SAMPLE_W'($urandom));
            if ($urandom_range(0, 15) == 0) wait_drained();
        end

        // A stretch with no idling on either side and the delay clamped to the ring depth.
        wait_drained();
        no_idle <= 1'b1;
        write_reg(CFG_ECHO_DELAY, 15'h3FFF);
        write_reg(CFG_VOLUME_DIVISOR, CFG_DATA_W'($urandom_range(1, 8)));
        repeat (48) send_item(CMD_PUSH, pick_sample());
        repeat (5) send_item(CMD_DRAIN, SAMPLE_W'($urandom));
        wait_drained();
        write_reg(CFG_ECHO_DELAY, CFG_DATA_W'(DEPTH));
        repeat (16) send_item(CMD_PUSH, pick_sample());
        no_idle <= 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Run covered %0d sample and %0d drain transactions across %0d register writes;",
                 n_push, n_drain, n_cfg);
        $display("%0d results carried the end-of-tail marker.", tail_marks);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/aedm_pkg.sv
src/aedm_div.sv
src/audio_echo_delay_mixer.sv
sim/aedm_echo_checker.sv
sim/tb_audio_echo_delay_mixer.sv
